// ===== hdl/dsng_pkg.sv =====
// ----------------------------------------------------------------------------
// dsng_pkg: types and constants for the decaying sine note generator
// Holds the state encoding, controller/datapath command and status bundles,
// the semitone ratio table and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package dsng_pkg;

   localparam int NOTE_COUNT     = 15;
   localparam int SINE_ADDR_BITS = 10;
   localparam int LENGTH_BITS    = 24;
   localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
   localparam int QUARTER_SIZE   = 1 << QUARTER_BITS;
   localparam int NOTE_BITS      = 4;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 31;
   localparam int DIV_STEPS      = LENGTH_BITS + 16;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_BASE_STEP  = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_LONG_LEN   = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SHORT_LEN  = 2'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FADE_LEN   = 2'd3;

   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START_FIN,
      ST_DECAY_INIT,
      ST_DECAY_RUN,
      ST_FADE_INIT,
      ST_FADE_RUN,
      ST_ENV_MUL,
      ST_SAMPLE_MUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic start_mul;    // latch note parameters, form step product
      logic start_fin;    // shift step, load note state
      logic decay_init;   // load divider with decay operands
      logic fade_init;    // load divider with fade operands
      logic div_step;     // one restoring division step
      logic decay_save;   // quotient to decay register
      logic fade_save;    // quotient to fade register
      logic env_mul;      // env = decay*fade >> 15
      logic sample_mul;   // mag = |s|*env >> 15
      logic out_load;     // result register load + state advance
      logic idle_out;     // result of a tick while idle
   } cmd_type;

   typedef struct packed {
      logic active;
      logic div_done;
   } status_type;

   localparam logic [31:0] SEMITONE_RATIO [12] = '{
      32'd1073741824, 32'd1137589835, 32'd1205234447, 32'd1276901417,
      32'd1352829926, 32'd1433273380, 32'd1518500250, 32'd1608794974,
      32'd1704458901, 32'd1805811301, 32'd1913190429, 32'd2026954652
   };

   // Semitone power above C3 for each scale step.
   function automatic logic [4:0] note_power(input logic [NOTE_BITS-1:0] n);
      logic [4:0] p;
      case (n)
         4'd0:    p = 5'd0;
         4'd1:    p = 5'd2;
         4'd2:    p = 5'd4;
         4'd3:    p = 5'd5;
         4'd4:    p = 5'd7;
         4'd5:    p = 5'd9;
         4'd6:    p = 5'd11;
         4'd7:    p = 5'd12;
         4'd8:    p = 5'd14;
         4'd9:    p = 5'd16;
         4'd10:   p = 5'd17;
         4'd11:   p = 5'd19;
         4'd12:   p = 5'd21;
         4'd13:   p = 5'd23;
         default: p = 5'd24;
      endcase
      return p;
   endfunction

   // Quarter-wave entry, Taylor series in Q30, evaluated at elaboration.
   function automatic logic [15:0] quarter_sine(input int q);
      logic [63:0] x, x2, term, sum, v;
      x = (64'(q) * 64'd6746518852) >> SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 6; n++) begin
         term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      return (v > 64'd32767) ? 16'd32767 : v[15:0];
   endfunction

   typedef logic [15:0] rom_type [QUARTER_SIZE + 1];

   function automatic rom_type build_rom();
      rom_type r;
      for (int q = 0; q <= QUARTER_SIZE; q++) begin
         r[q] = quarter_sine(q);
      end
      return r;
   endfunction

   localparam rom_type QUARTER_ROM = build_rom();

endpackage

// ===== hdl/dsng_if.sv =====
// ----------------------------------------------------------------------------
// dsng_req_if / dsng_rsp_if: valid/ready channels of the note generator
// Request carries op, note and length choice; response carries one sample.
// ----------------------------------------------------------------------------
interface dsng_req_if;
   logic                           valid;
   logic                           ready;
   logic                           op;
   logic [dsng_pkg::NOTE_BITS-1:0] note_index;
   logic                           length_select;
   modport source (output valid, op, note_index, length_select, input ready);
   modport sink (input valid, op, note_index, length_select, output ready);
endinterface

interface dsng_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample;
   logic               last_sample;
   logic               playing;
   modport source (output valid, sample, last_sample, playing, input ready);
   modport sink (input valid, sample, last_sample, playing, output ready);
endinterface

// ===== hdl/decaying_sine_note_generator.sv =====
// ----------------------------------------------------------------------------
// decaying_sine_note_generator: sine tone with linear decay and fade-in
// Start beats choose a note and length; each tick beat yields one sample.
// ----------------------------------------------------------------------------
//  channel | dir | beat contents
//  req     | in  | op, note_index, length_select
//  rsp     | out | sample, last_sample, playing
//  csr     | in  | write enable, index, 31-bit data
//
// Start beat: step multiply in the accept cycle, then octave shift and load.
// Tick beat while playing: the bit-serial divider runs once for the decay and
// once for the fade factor (load, 40 division steps and a save each), then the
// envelope and sample multiplies and the result load; the next request is
// accepted only after that. Tick while idle: a silent beat. Synchronous reset
// clears the note state; the result register holds a beat under rsp stall,
// and a finished sample or an idle tick waits for the slot to free.
module decaying_sine_note_generator (
   input  logic                                   clock,
   input  logic                                   reset,
   dsng_req_if.sink                               req,
   dsng_rsp_if.source                             rsp,
   input  logic                                   csr_write,
   input  logic [dsng_pkg::CSR_ADDR_BITS-1:0]     csr_index,
   input  logic [dsng_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   dsng_pkg::cmd_type    cmd;
   dsng_pkg::status_type status;
   logic                 out_free;
   logic                 req_ready;

   assign req.ready = req_ready;

   dsng_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_op    (req.op),
      .req_ready (req_ready),
      .out_free  (out_free),
      .status    (status),
      .cmd       (cmd)
   );

   dsng_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_note_index    (req.note_index),
      .req_length_select (req.length_select),
      .cmd               (cmd),
      .status            (status),
      .out_free          (out_free),
      .rsp_valid         (rsp.valid),
      .rsp_ready         (rsp.ready),
      .rsp_sample        (rsp.sample),
      .rsp_last_sample   (rsp.last_sample),
      .rsp_playing       (rsp.playing)
   );

endmodule

// ===== hdl/dsng_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsng_ctrl: sequencer of the note generator
// Steps start and tick items through multiply and divide phases.
// ----------------------------------------------------------------------------
module dsng_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_op,
   output logic                 req_ready,
   input  logic                 out_free,
   input  dsng_pkg::status_type status,
   output dsng_pkg::cmd_type    cmd
);

   dsng_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dsng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsng_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_op == dsng_pkg::OP_START) begin
                  state_in = dsng_pkg::ST_START_FIN;
               end else if (status.active) begin
                  state_in = dsng_pkg::ST_DECAY_INIT;
               end
            end
         end
         dsng_pkg::ST_START_FIN:  state_in = dsng_pkg::ST_IDLE;
         dsng_pkg::ST_DECAY_INIT: state_in = dsng_pkg::ST_DECAY_RUN;
         dsng_pkg::ST_DECAY_RUN: begin
            if (status.div_done) begin
               state_in = dsng_pkg::ST_FADE_INIT;
            end
         end
         dsng_pkg::ST_FADE_INIT:  state_in = dsng_pkg::ST_FADE_RUN;
         dsng_pkg::ST_FADE_RUN: begin
            if (status.div_done) begin
               state_in = dsng_pkg::ST_ENV_MUL;
            end
         end
         dsng_pkg::ST_ENV_MUL:    state_in = dsng_pkg::ST_SAMPLE_MUL;
         dsng_pkg::ST_SAMPLE_MUL: state_in = dsng_pkg::ST_OUT;
         dsng_pkg::ST_OUT: begin
            if (out_free) begin
               state_in = dsng_pkg::ST_IDLE;
            end
         end
         default: state_in = dsng_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         dsng_pkg::ST_IDLE: begin
            // idle ticks need a free result slot
            req_ready = (req_op == dsng_pkg::OP_START) || status.active || out_free;
            // note fields are taken in the accept cycle
            cmd.start_mul = req_valid && req_op == dsng_pkg::OP_START;
            cmd.idle_out = req_valid && req_op == dsng_pkg::OP_TICK && !status.active
                           && out_free;
         end
         dsng_pkg::ST_START_FIN:  cmd.start_fin = 1'b1;
         dsng_pkg::ST_DECAY_INIT: cmd.decay_init = 1'b1;
         dsng_pkg::ST_DECAY_RUN: begin
            cmd.div_step = !status.div_done;
            cmd.decay_save = status.div_done;
         end
         dsng_pkg::ST_FADE_INIT:  cmd.fade_init = 1'b1;
         dsng_pkg::ST_FADE_RUN: begin
            cmd.div_step = !status.div_done;
            cmd.fade_save = status.div_done;
         end
         dsng_pkg::ST_ENV_MUL:    cmd.env_mul = 1'b1;
         dsng_pkg::ST_SAMPLE_MUL: cmd.sample_mul = 1'b1;
         dsng_pkg::ST_OUT:        cmd.out_load = out_free;
         default: cmd = '0;
      endcase
   end

endmodule

// ===== hdl/dsng_datapath.sv =====
// ----------------------------------------------------------------------------
// dsng_datapath: note state, serial divider, multipliers and sine table
// Acts on controller commands; holds configuration and result register.
// ----------------------------------------------------------------------------
module dsng_datapath (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_write,
   input  logic [dsng_pkg::CSR_ADDR_BITS-1:0]       csr_index,
   input  logic [dsng_pkg::CSR_DATA_BITS-1:0]       csr_data,
   input  logic [dsng_pkg::NOTE_BITS-1:0]           req_note_index,
   input  logic                                     req_length_select,
   input  dsng_pkg::cmd_type                        cmd,
   output dsng_pkg::status_type                     status,
   output logic                                     out_free,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [15:0]                       rsp_sample,
   output logic                                     rsp_last_sample,
   output logic                                     rsp_playing
);

   localparam int LB = dsng_pkg::LENGTH_BITS;
   localparam int NB = LB + 16;         // dividend width
   localparam int CB = $clog2(dsng_pkg::DIV_STEPS + 1);

   logic [30:0] base_ff;
   logic [LB-1:0] long_ff, short_ff;
   logic [9:0] fade_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= 31'd12739990;
         long_ff <= LB'(44100);
         short_ff <= LB'(11025);
         fade_cfg_ff <= 10'd100;
      end else if (csr_write) begin
         case (csr_index)
            dsng_pkg::CSR_BASE_STEP: base_ff <= csr_data;
            dsng_pkg::CSR_LONG_LEN:  long_ff <= LB'(csr_data[23:0]);
            dsng_pkg::CSR_SHORT_LEN: short_ff <= LB'(csr_data[23:0]);
            dsng_pkg::CSR_FADE_LEN:  fade_cfg_ff <= csr_data[9:0];
            default: ;
         endcase
      end
   end

   // note state
   logic [31:0] phase_ff, step_ff;
   logic [LB-1:0] pos_ff, len_ff, fade_ff;
   logic active_ff;
   logic [2:0] oct_ff;
   logic [62:0] prod_ff;
   logic [LB-1:0] plen_ff;

   logic [3:0] note_sat;
   logic [4:0] pw;
   logic [1:0] pw_oct;
   logic [3:0] pw_semi;
   logic [LB-1:0] len_sel;
   logic [LB-1:0] fade_ext;
   logic last_w;

   assign note_sat = (req_note_index > 4'(dsng_pkg::NOTE_COUNT - 1))
                     ? 4'(dsng_pkg::NOTE_COUNT - 1) : req_note_index;
   assign pw = dsng_pkg::note_power(note_sat);
   // octave and semitone of the power (power is at most 24)
   assign pw_oct = (pw >= 5'd24) ? 2'd2 : ((pw >= 5'd12) ? 2'd1 : 2'd0);
   assign pw_semi = (pw >= 5'd24) ? 4'(pw - 5'd24)
                    : ((pw >= 5'd12) ? 4'(pw - 5'd12) : 4'(pw));
   assign len_sel = req_length_select ? short_ff : long_ff;
   assign fade_ext = LB'(fade_cfg_ff);
   assign last_w = (pos_ff + LB'(1) >= len_ff) || (pos_ff == {LB{1'b1}});

   // divider
   logic [NB-1:0] dq_ff;       // dividend shifting into quotient
   logic [LB:0] rem_ff;
   logic [LB-1:0] dvs_ff;
   logic [CB-1:0] cnt_ff;
   logic [LB:0] trial;
   logic [16:0] decay_ff, fade_f_ff;
   logic [16:0] env_ff;
   logic [15:0] mag_ff;
   logic neg_ff;

   assign trial = {rem_ff[LB-1:0], dq_ff[NB-1]} - {1'b0, dvs_ff};
   assign status.div_done = (cnt_ff == '0);
   assign status.active = active_ff;

   // sine lookup
   logic [dsng_pkg::SINE_ADDR_BITS-1:0] addr;
   logic [dsng_pkg::QUARTER_BITS-1:0] r;
   logic [dsng_pkg::QUARTER_BITS:0] idx;
   logic [15:0] sval;

   assign addr = phase_ff[31 -: dsng_pkg::SINE_ADDR_BITS];
   assign r = addr[dsng_pkg::QUARTER_BITS-1:0];
   assign idx = addr[dsng_pkg::QUARTER_BITS]
                ? (dsng_pkg::QUARTER_BITS+1)'(dsng_pkg::QUARTER_SIZE) - {1'b0, r}
                : {1'b0, r};
   assign sval = dsng_pkg::QUARTER_ROM[idx];

   logic [33:0] env_prod;
   logic [32:0] mag_prod;
   assign env_prod = decay_ff * fade_f_ff;
   assign mag_prod = sval * env_ff;

   logic rsp_valid_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         phase_ff <= '0;
         step_ff <= '0;
         pos_ff <= '0;
         len_ff <= '0;
         fade_ff <= '0;
      end else begin
         // a new beat may load in the cycle the old one leaves
         if (cmd.out_load || cmd.idle_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.start_mul) begin
            prod_ff <= base_ff * dsng_pkg::SEMITONE_RATIO[pw_semi];
            oct_ff <= {1'b0, pw_oct};
            plen_ff <= len_sel;
         end
         if (cmd.start_fin) begin
            step_ff <= prod_ff[61:30] << oct_ff;
            phase_ff <= '0;
            pos_ff <= '0;
            len_ff <= plen_ff;
            fade_ff <= (fade_ext > plen_ff) ? (plen_ff >> 1) : fade_ext;
            active_ff <= plen_ff != '0;
         end
         if (cmd.decay_init) begin
            dq_ff <= {len_ff - LB'(1) - pos_ff, 15'd0, 1'b0} >> 1;
            dvs_ff <= len_ff - LB'(1);
            rem_ff <= '0;
            cnt_ff <= CB'(NB);
         end
         if (cmd.fade_init) begin
            dq_ff <= NB'({pos_ff, 15'd0});
            dvs_ff <= fade_ff - LB'(1);
            rem_ff <= '0;
            cnt_ff <= CB'(NB);
         end
         if (cmd.div_step) begin
            if (!trial[LB]) begin
               rem_ff <= trial;
               dq_ff <= {dq_ff[NB-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[LB-1:0], dq_ff[NB-1]};
               dq_ff <= {dq_ff[NB-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff - CB'(1);
         end
         if (cmd.decay_save) begin
            decay_ff <= (len_ff >= LB'(2)) ? dq_ff[16:0] : 17'd32768;
         end
         if (cmd.fade_save) begin
            fade_f_ff <= (fade_ff >= LB'(2) && pos_ff < fade_ff)
                         ? dq_ff[16:0] : 17'd32768;
         end
         if (cmd.env_mul) begin
            env_ff <= env_prod[31:15];
         end
         if (cmd.sample_mul) begin
            mag_ff <= mag_prod[30:15];
            neg_ff <= addr[dsng_pkg::SINE_ADDR_BITS-1];
         end
         if (cmd.out_load) begin
            rsp_sample <= neg_ff ? -$signed(mag_ff) : $signed(mag_ff);
            rsp_last_sample <= last_w;
            rsp_playing <= 1'b1;
            phase_ff <= phase_ff + step_ff;
            pos_ff <= pos_ff + LB'(1);
            if (last_w) begin
               active_ff <= 1'b0;
            end
         end
         if (cmd.idle_out) begin
            rsp_sample <= '0;
            rsp_last_sample <= 1'b0;
            rsp_playing <= 1'b0;
         end
      end
   end

endmodule

// ===== test/decaying_sine_note_generator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// decaying_sine_note_generator_tb: self-checking bench for the note generator
// Drives start and tick beats with bursty gaps, stalls the sample channel on
// its own pattern, and checks every sample beat against an in-bench model of
// the phase accumulator, sine table and decay/fade envelope.
// ----------------------------------------------------------------------------
module decaying_sine_note_generator_tb;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [dsng_pkg::CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [dsng_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   dsng_req_if req ();
   dsng_rsp_if rsp ();

   decaying_sine_note_generator dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected sample beat.
   typedef struct {
      logic signed [15:0] sample;
      logic               last_sample;
      logic               playing;
   } sample_beat_type;

   // Stimulus row: expected beat typed in only when obvious.
   typedef struct {
      logic       op;
      logic [3:0] note_index;
      logic       length_select;
      bit         typed;
      logic signed [15:0] sample;
      logic       last_sample;
      logic       playing;
   } stim_row_type;

   sample_beat_type expected_samples[$];
   int errors = 0;

   // Tone generator shadow state.
   logic [30:0] reg_base_step;
   logic [23:0] reg_long_len, reg_short_len;
   logic [9:0]  reg_fade_len;
   logic [31:0] tone_phase, tone_step;
   logic [23:0] tone_pos, tone_len, tone_fade;
   bit          tone_active;

   // Quarter table computed independently of the package.
   logic [15:0] sine_quarter [dsng_pkg::QUARTER_SIZE + 1];

   function automatic logic [15:0] taylor_sine(int q);
      logic [63:0] x, x2, t, s, v;
      x  = (64'(q) * 64'd6746518852) >> dsng_pkg::SINE_ADDR_BITS;
      x2 = (x * x) >> 30;
      t  = x;
      s  = x;
      for (int n = 1; n <= 6; n++) begin
         t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n % 2 == 1) begin
            s = s - t;
         end else begin
            s = s + t;
         end
      end
      v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
      return (v > 64'd32767) ? 16'd32767 : v[15:0];
   endfunction

   task automatic shadow_reset();
      for (int q = 0; q <= dsng_pkg::QUARTER_SIZE; q++) begin
         sine_quarter[q] = taylor_sine(q);
      end
      reg_base_step = 31'd12739990;
      reg_long_len  = 24'd44100;
      reg_short_len = 24'd11025;
      reg_fade_len  = 10'd100;
      tone_phase = '0;
      tone_step  = '0;
      tone_pos   = '0;
      tone_len   = '0;
      tone_fade  = '0;
      tone_active = 1'b0;
   endtask

   task automatic shadow_start(logic [3:0] note, logic sel);
      int power;
      int steps [7] = '{2, 2, 1, 2, 2, 2, 1};
      logic [63:0] prod;
      logic [3:0] n;
      n = (note > 4'(dsng_pkg::NOTE_COUNT - 1)) ? 4'(dsng_pkg::NOTE_COUNT - 1) : note;
      power = 0;
      for (int j = 0; j < n; j++) begin
         power += steps[j % 7];
      end
      prod = (64'(reg_base_step) * 64'(dsng_pkg::SEMITONE_RATIO[power % 12])) >> 30;
      prod = prod << (power / 12);
      tone_step  = prod[31:0];
      tone_phase = '0;
      tone_pos   = '0;
      tone_len   = sel ? reg_short_len : reg_long_len;
      tone_fade  = 24'(reg_fade_len);
      if (tone_fade > tone_len) begin
         tone_fade = tone_len / 2;
      end
      tone_active = (tone_len != 0);
   endtask

   function automatic sample_beat_type shadow_tick();
      sample_beat_type b;
      logic [63:0] i, len, decay, fade, env, mag;
      logic [9:0]  addr;
      logic [1:0]  quad;
      logic [7:0]  r;
      int          s;
      if (!tone_active) begin
         b.sample = '0;
         b.last_sample = 1'b0;
         b.playing = 1'b0;
         return b;
      end
      i   = 64'(tone_pos);
      len = 64'(tone_len);
      decay = (len >= 2) ? (((len - 1 - i) << 15) / (len - 1)) : 64'd32768;
      if (tone_fade >= 2 && i < 64'(tone_fade)) begin
         fade = (i << 15) / (64'(tone_fade) - 1);
      end else begin
         fade = 64'd32768;
      end
      env  = (decay * fade) >> 15;
      addr = tone_phase[31 -: dsng_pkg::SINE_ADDR_BITS];
      quad = addr[9:8];
      r    = addr[7:0];
      s    = int'(sine_quarter[quad[0] ? (dsng_pkg::QUARTER_SIZE - int'(r)) : int'(r)]);
      mag  = (64'(s) * env) >> 15;
      b.sample = quad[1] ? -16'(mag) : 16'(mag);
      b.last_sample = (i + 1 >= len);
      b.playing = 1'b1;
      tone_phase = tone_phase + tone_step;
      tone_pos   = 24'(i + 1);
      if (b.last_sample) begin
         tone_active = 1'b0;
      end
      return b;
   endfunction

   // Register write at an idle moment; shadow follows.
   task automatic csr_put(logic [dsng_pkg::CSR_ADDR_BITS-1:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         dsng_pkg::CSR_BASE_STEP: reg_base_step = value;
         dsng_pkg::CSR_LONG_LEN:  reg_long_len  = value[23:0];
         dsng_pkg::CSR_SHORT_LEN: reg_short_len = value[23:0];
         dsng_pkg::CSR_FADE_LEN:  reg_fade_len  = value[9:0];
         default: ;
      endcase
   endtask

   // Sender: one beat, with burst/gap pacing between beats.
   int burst_left = 0;

   task automatic send_beat(logic op, logic [3:0] note, logic sel);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req.valid         <= 1'b1;
      req.op            <= op;
      req.note_index    <= note;
      req.length_select <= sel;
      do @(posedge clock); while (!req.ready);
      if (op == dsng_pkg::OP_START) begin
         shadow_start(note, sel);
      end else begin
         expected_samples.insert(expected_samples.size(), shadow_tick());
      end
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      // A start beat carries no result; give the block time to settle.
      repeat (100) @(negedge clock);
   endtask

   // Receiver stall pattern: random open and stalled stretches.
   int stall_count = 0;
   always @(negedge clock) begin
      if (stall_count == 0) begin
         stall_count = $urandom_range(1, 40);
         rsp.ready <= ($urandom_range(0, 2) != 0);
      end else begin
         stall_count--;
      end
   end

   // Result checker.
   always @(posedge clock) begin
      sample_beat_type exp_b;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_samples.size() == 0) begin
            $display("%0t: unexpected sample beat %0d", $time, rsp.sample);
            errors++;
         end else begin
            exp_b = expected_samples.pop_front();
            if (rsp.sample !== exp_b.sample) begin
               $display("%0t: sample expected %0d actual %0d",
                        $time, exp_b.sample, rsp.sample);
               errors++;
            end
            if (rsp.last_sample !== exp_b.last_sample) begin
               $display("%0t: last_sample expected %0b actual %0b",
                        $time, exp_b.last_sample, rsp.last_sample);
               errors++;
            end
            if (rsp.playing !== exp_b.playing) begin
               $display("%0t: playing expected %0b actual %0b",
                        $time, exp_b.playing, rsp.playing);
               errors++;
            end
         end
      end
   end

   // Directed rows. Idle ticks have an obvious result, typed in.
   stim_row_type directed_rows [] = '{
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 1, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd15, 1'b1, 1, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_START, 4'd15, 1'b1, 0, 16'sd0, 1'b0, 1'b0},  // index saturates
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_START, 4'd14, 1'b0, 0, 16'sd0, 1'b0, 1'b0},  // restart mid note
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_START, 4'd0,  1'b1, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0},
      '{dsng_pkg::OP_TICK,  4'd0,  1'b0, 0, 16'sd0, 1'b0, 1'b0}
   };

   task automatic play_directed();
      foreach (directed_rows[k]) begin
         send_beat(directed_rows[k].op, directed_rows[k].note_index,
                   directed_rows[k].length_select);
         if (directed_rows[k].typed) begin
            expected_samples[$].sample      = directed_rows[k].sample;
            expected_samples[$].last_sample = directed_rows[k].last_sample;
            expected_samples[$].playing     = directed_rows[k].playing;
         end
      end
   endtask

   // Random part: mostly start followed by a run of ticks, some noise.
   task automatic play_random(int beats);
      int n;
      int run;
      n = 0;
      while (n < beats) begin
         if ($urandom_range(0, 9) != 0) begin
            send_beat(dsng_pkg::OP_START, 4'($urandom_range(0, 15)), 1'($urandom));
            run = $urandom_range(1, 40);
            for (int k = 0; k < run; k++) begin
               send_beat(dsng_pkg::OP_TICK, 4'($urandom), 1'($urandom));
            end
            n += run + 1;
         end else begin
            send_beat(1'($urandom), 4'($urandom), 1'($urandom));
            n++;
         end
      end
   endtask

   initial begin
      req.valid = 1'b0;
      req.op = dsng_pkg::OP_TICK;
      req.note_index = '0;
      req.length_select = 1'b0;
      rsp.ready = 1'b0;
      shadow_reset();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset defaults, plus the special cases under short settings.
      play_directed();
      drain();

      // Tiny notes: one-sample and zero-sample notes, fade count of one.
      csr_put(dsng_pkg::CSR_LONG_LEN, 31'd1);
      csr_put(dsng_pkg::CSR_SHORT_LEN, 31'd0);
      csr_put(dsng_pkg::CSR_FADE_LEN, 31'd1);
      csr_put(dsng_pkg::CSR_BASE_STEP, 31'h7FFFFFFF);
      play_random(100);
      drain();

      // Fade longer than note, fade at maximum.
      csr_put(dsng_pkg::CSR_LONG_LEN, 31'd2);
      csr_put(dsng_pkg::CSR_SHORT_LEN, 31'd30);
      csr_put(dsng_pkg::CSR_FADE_LEN, 31'd1023);
      csr_put(dsng_pkg::CSR_BASE_STEP, 31'd0);
      play_random(250);
      drain();

      // Long maximum note, all-ones data written to the long length.
      csr_put(dsng_pkg::CSR_LONG_LEN, 31'h7FFFFFFF);
      csr_put(dsng_pkg::CSR_SHORT_LEN, 31'd17);
      csr_put(dsng_pkg::CSR_FADE_LEN, 31'd5);
      csr_put(dsng_pkg::CSR_BASE_STEP, 31'($urandom));
      play_random(300);
      drain();

      // Random mid-range settings.
      for (int p = 0; p < 3; p++) begin
         csr_put(dsng_pkg::CSR_LONG_LEN, 31'($urandom_range(2, 60)));
         csr_put(dsng_pkg::CSR_SHORT_LEN, 31'($urandom_range(2, 25)));
         csr_put(dsng_pkg::CSR_FADE_LEN, 31'($urandom_range(1, 40)));
         csr_put(dsng_pkg::CSR_BASE_STEP, 31'($urandom));
         play_random(220);
         drain();
      end

      if (errors == 0) begin
         $display("[decaying_sine_note_generator] OK");
      end else begin
         $display("[decaying_sine_note_generator] ERROR");
      end
      $finish;
   end

   // Watchdog: ~1500 beats, each a tick computation plus stalls and gaps, padded.
   initial begin
      #20ms;
      $display("[decaying_sine_note_generator] ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/dsng_pkg.sv
hdl/dsng_if.sv
hdl/dsng_ctrl.sv
hdl/dsng_datapath.sv
hdl/decaying_sine_note_generator.sv
test/decaying_sine_note_generator_tb.sv
